FILE: rtl/core/xeu_pkg.sv
// shared types and constants for the xml entity unescape unit
`default_nettype none
package xeu_pkg;

  localparam int unsigned ENT_NUM  = 5;
  localparam int unsigned SEQ_LEN  = 6;
  localparam int unsigned HOLD_NUM = 4;

  localparam logic [7:0] AMP_CHAR = 8'h26;
  localparam logic [ENT_NUM-1:0] ALL_ENTS = '1;

  // entity names after the '&', order lt, gt, amp, apos, quot
  localparam logic [7:0] ENT_TEXT [ENT_NUM][5] = '{
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
  };
  localparam logic [2:0] ENT_SIZE [ENT_NUM] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] ENT_PLAIN [ENT_NUM] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

  // decoded bytes produced by one input item
  typedef struct packed {
    logic [SEQ_LEN-1:0][7:0] seq;
    logic [2:0]              cnt;
    logic                    last;
  } grp_t;

endpackage
`default_nettype wire

FILE: rtl/core/xml_entity_unescape_unit.sv
// top level of the xml predefined entity decoder
//
// channel | dir | tdata            | tlast    | tuser
// in_     | in  | [7:0] byte       | in_last  | -
// out_    | out | [7:0] byte       | run_last | [0] text_end
//
// one input item per cycle while the queue has room; an item gives 0 to 6 bytes
// the output side moves one byte per cycle while out_tready is high, so items of more
// than one byte back-pressure the input once the group queue (FIFO_DEPTH entries) fills
// zero-result items (bytes held inside an open entity) push nothing into the queue
// synchronous active-low reset clears matcher state, queue and byte index
`default_nettype none
module xml_entity_unescape_unit #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,
  output logic [0:0]      out_tuser   // [0] text_end
);
  import xeu_pkg::*;

  grp_t push_grp, head_grp;
  logic push, pop, full, valid;

  xeu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_grp     (push_grp)
  );

  xeu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .full     (full),
    .valid    (valid),
    .head     (head_grp)
  );

  xeu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (valid),
    .q_head     (head_grp),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: rtl/core/xeu_front.sv
// front end: entity matcher that turns each input item into a byte group
`default_nettype none
module xeu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          in_tlast,
  input  wire logic          q_full,
  output logic               q_push,
  output xeu_pkg::grp_t      q_grp
);
  import xeu_pkg::*;

  logic [ENT_NUM-1:0] mask_r, mask_nxt;
  logic [2:0]         held_cnt_r, cnt_nxt;
  logic [7:0]         held_r [HOLD_NUM];

  logic [7:0]         b;
  logic               acc;
  logic [2:0]         pos;
  logic [ENT_NUM-1:0] keep;
  logic               done_hit;
  logic [2:0]         done_idx;
  logic               flush, tail, hold_we;
  logic [2:0]         flush_n;
  logic [7:0]         tail_b;

  assign b         = in_tdata;
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign pos       = held_cnt_r;

  always_comb begin
    keep     = '0;
    done_hit = 1'b0;
    done_idx = '0;
    for (int e = 0; e < ENT_NUM; e++) begin
      if (mask_r[e] && pos < ENT_SIZE[e] && ENT_TEXT[e][pos] == b) begin
        keep[e] = 1'b1;
        if (pos + 3'd1 == ENT_SIZE[e]) begin
          done_hit = 1'b1;
          done_idx = 3'(e);
        end
      end
    end
  end

  always_comb begin
    flush    = 1'b0;
    flush_n  = pos;
    tail     = 1'b0;
    tail_b   = b;
    mask_nxt = mask_r;
    cnt_nxt  = held_cnt_r;
    hold_we  = 1'b0;
    if (mask_r == '0) begin
      if (b == AMP_CHAR) begin
        tail     = in_tlast;
        mask_nxt = in_tlast ? '0 : ALL_ENTS;
        cnt_nxt  = '0;
      end else begin
        tail = 1'b1;
      end
    end else if (done_hit) begin
      tail     = 1'b1;
      tail_b   = ENT_PLAIN[done_idx];
      mask_nxt = '0;
      cnt_nxt  = '0;
    end else if (keep != '0 && pos < 3'(HOLD_NUM)) begin
      hold_we = 1'b1;
      if (in_tlast) begin
        // string ends inside an entity: everything goes out raw
        flush    = 1'b1;
        tail     = 1'b1;
        mask_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        mask_nxt = keep;
        cnt_nxt  = pos + 3'd1;
      end
    end else begin
      // mismatch: raw '&' and held bytes, then the byte as fresh input
      flush = 1'b1;
      if (b == AMP_CHAR) begin
        tail     = in_tlast;
        mask_nxt = in_tlast ? '0 : ALL_ENTS;
      end else begin
        tail     = 1'b1;
        mask_nxt = '0;
      end
      cnt_nxt = '0;
    end
  end

  always_comb begin
    q_grp.seq[0] = flush ? AMP_CHAR : tail_b;
    for (int k = 1; k < SEQ_LEN; k++) begin
      if (k <= HOLD_NUM) begin
        q_grp.seq[k] = held_r[k-1];
      end else begin
        q_grp.seq[k] = tail_b;
      end
      if (flush && flush_n + 3'd1 == 3'(k)) begin
        q_grp.seq[k] = tail_b;
      end
    end
    q_grp.cnt  = (flush ? flush_n + 3'd1 : 3'd0) + {2'b00, tail};
    q_grp.last = in_tlast;
  end

  assign q_push = acc && (flush || tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      held_cnt_r <= '0;
    end else if (acc) begin
      mask_r     <= mask_nxt;
      held_cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hold_we) begin
      held_r[pos[1:0]] <= b;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/xeu_fifo.sv
// short queue of byte groups between matcher and serializer
`default_nettype none
module xeu_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire xeu_pkg::grp_t push_grp,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output xeu_pkg::grp_t      head
);
  import xeu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign valid   = cnt_r != '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/xeu_back.sv
// back end: gives out the bytes of the head group one per cycle while out_tready is high
`default_nettype none
module xeu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire xeu_pkg::grp_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [0:0]         out_tuser
);
  import xeu_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign out_tvalid   = q_valid;
  assign out_tdata    = q_head.seq[idx_r];
  assign out_tlast    = idx_r == q_head.cnt - 3'd1;
  assign out_tuser[0] = out_tlast && q_head.last;
  assign acc          = out_tvalid && out_tready;
  assign q_pop        = acc && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    if (acc) begin
      idx_nxt = out_tlast ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/xeu_checker.sv
// port-level checks for the xml entity unescape unit, with bind
`default_nettype none
module xeu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [0:0] out_tuser
);

  // text end is only flagged on the final byte of an item
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[0] || out_tlast))
    else $error("text_end without run_last");

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a stalled output item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled output item keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

endmodule

bind xml_entity_unescape_unit xeu_checker u_xeu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

FILE: tb/sv/tb_xml_entity_unescape_unit.sv
// self-checking testbench for the xml entity unescape unit
`timescale 1ns / 1ps
`default_nettype none
module tb_xml_entity_unescape_unit;

  localparam logic [7:0] AMP_CH     = 8'h26;
  localparam int         RAND_ITEMS = 330;
  localparam int         TAIL       = 16;
  localparam int         LIMIT      = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } dec_res_t;

  typedef struct packed {
    logic       typed;
    logic [7:0] want;
  } row_tag_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [7:0] want;
  } dir_row_t;

  // typed rows carry their single expected byte, the rest go through the decoder copy
  localparam dir_row_t DIR_ROWS [25] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'hff, 1'b1, 1'b1, 8'hff},
    '{AMP_CH, 1'b0, 1'b0, 8'h00}, '{"l", 1'b0, 1'b0, 8'h00},
    '{"t", 1'b0, 1'b0, 8'h00},    '{";", 1'b0, 1'b0, 8'h00},
    '{AMP_CH, 1'b0, 1'b0, 8'h00}, '{"q", 1'b0, 1'b0, 8'h00},
    '{"u", 1'b0, 1'b0, 8'h00},    '{"o", 1'b0, 1'b0, 8'h00},
    '{"t", 1'b0, 1'b0, 8'h00},    '{";", 1'b0, 1'b0, 8'h00},
    // mismatch after a shared prefix
    '{AMP_CH, 1'b0, 1'b0, 8'h00}, '{"a", 1'b0, 1'b0, 8'h00},
    '{"p", 1'b0, 1'b0, 8'h00},    '{"x", 1'b0, 1'b0, 8'h00},
    // second ampersand restarts the match
    '{AMP_CH, 1'b0, 1'b0, 8'h00}, '{AMP_CH, 1'b0, 1'b0, 8'h00},
    '{"g", 1'b0, 1'b0, 8'h00},    '{"t", 1'b0, 1'b0, 8'h00},
    '{";", 1'b0, 1'b0, 8'h00},
    // string ends inside an entity
    '{AMP_CH, 1'b0, 1'b0, 8'h00}, '{"a", 1'b0, 1'b0, 8'h00},
    '{"m", 1'b1, 1'b0, 8'h00},
    // lone ampersand ends the string
    '{AMP_CH, 1'b1, 1'b1, AMP_CH}
  };

  localparam logic [7:0] ENT_CHAR [5] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [0:0] out_tuser;

  logic calm = 1'b0;

  // decoder copy
  logic [4:0] dec_mask = '0;
  logic [2:0] dec_held_cnt = '0;
  logic [7:0] dec_held [4];
  logic [7:0] dec_bytes [$];

  dec_res_t exp_q [$];
  row_tag_t row_q [$];

  int n_err     = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_strings = 0;
  int cyc       = 0;

  xml_entity_unescape_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic string ent_str(input int e);
    case (e)
      0: return "lt;";
      1: return "gt;";
      2: return "amp;";
      3: return "apos;";
      default: return "quot;";
    endcase
  endfunction

  task automatic flush_held();
    dec_bytes.push_back(AMP_CH);
    for (int i = 0; i < dec_held_cnt; i++) dec_bytes.push_back(dec_held[i]);
    dec_mask = '0;
    dec_held_cnt = '0;
  endtask

  task automatic open_or_pass(input logic [7:0] b);
    if (b == AMP_CH) begin
      dec_mask = '1;
      dec_held_cnt = '0;
    end else begin
      dec_bytes.push_back(b);
    end
  endtask

  task automatic decode_item(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [7:0] want);
    string      s;
    int         done;
    int         pos;
    int         n;
    logic [4:0] keep;
    dec_bytes.delete();
    if (dec_mask == '0) begin
      open_or_pass(b);
    end else begin
      pos  = dec_held_cnt;
      keep = '0;
      done = -1;
      for (int e = 0; e < 5; e++) begin
        s = ent_str(e);
        if (dec_mask[e] && pos < s.len() && s[pos] == b) begin
          keep[e] = 1'b1;
          if (pos + 1 == s.len()) done = e;
        end
      end
      if (done >= 0) begin
        dec_bytes.push_back(ENT_CHAR[done]);
        dec_mask = '0;
        dec_held_cnt = '0;
      end else if (keep != '0 && pos < 4) begin
        dec_held[pos] = b;
        dec_held_cnt = 3'(pos + 1);
        dec_mask = keep;
      end else begin
        flush_held();
        open_or_pass(b);
      end
    end
    if (fin && dec_mask != '0) flush_held();
    if (typed) begin
      dec_bytes.delete();
      dec_bytes.push_back(want);
    end
    n = dec_bytes.size();
    for (int k = 0; k < n; k++)
      exp_q.push_back(dec_res_t'{dec_bytes[k], k == n - 1, (k == n - 1) && fin});
  endtask

  task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [7:0] want);
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    row_q.push_back(row_tag_t'{typed, want});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // input prediction and output checking share one process so order within an edge is fixed
  always @(posedge clk) begin
    dec_res_t got;
    dec_res_t want;
    row_tag_t tag;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tag = row_q.pop_front();
        decode_item(in_tdata, in_tlast, tag.typed, tag.want);
        n_items++;
        if (in_tlast) n_strings++;
      end
      if (out_tvalid && out_tready) begin
        got = dec_res_t'{out_tdata, out_tlast, out_tuser[0]};
        n_results++;
        if (exp_q.size() == 0) begin
          if (n_err < 10)
            $display("unexpected item: byte %02h last %0b end %0b",
                     got.data, got.run_last, got.text_end);
          n_err++;
        end else begin
          want = exp_q.pop_front();
          if (got !== want) begin
            if (n_err < 10)
              $display("mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                       want.data, want.run_last, want.text_end,
                       got.data, got.run_last, got.text_end);
            n_err++;
          end
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] tok [$];
    string      s;
    int         n_rand;
    int         kind;
    int         plen;
    logic       fin;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[r])
      send_item(DIR_ROWS[r].b, DIR_ROWS[r].fin, DIR_ROWS[r].typed, DIR_ROWS[r].want);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      tok.delete();
      kind = $urandom_range(99);
      s = ent_str($urandom_range(4));
      if (kind < 30) begin
        tok.push_back(AMP_CH);
        for (int k = 0; k < s.len(); k++) tok.push_back(s[k]);
      end else if (kind < 50) begin
        // broken entity: a proper prefix then an ampersand or a random byte
        plen = $urandom_range(s.len() - 1, 1);
        tok.push_back(AMP_CH);
        for (int k = 0; k < plen; k++) tok.push_back(s[k]);
        tok.push_back(($urandom_range(2) == 0) ? AMP_CH : 8'($urandom_range(255)));
      end else if (kind < 65) begin
        repeat ($urandom_range(3, 1)) tok.push_back(8'($urandom_range(255)));
      end else if (kind < 75) begin
        tok.push_back(AMP_CH);
        tok.push_back(8'($urandom_range(255)));
      end else if (kind < 85) begin
        tok.push_back(AMP_CH);
        tok.push_back(AMP_CH);
        for (int k = 0; k < s.len(); k++) tok.push_back(s[k]);
      end else begin
        tok.push_back(8'($urandom_range(255)));
      end
      foreach (tok[k]) begin
        calm = (n_rand >= 150 && n_rand < 230);
        fin = ($urandom_range(9) == 0);
        send_item(tok[k], fin, 1'b0, 8'h00);
        n_rand++;
      end
    end
    calm = 1'b0;
    send_item(8'($urandom_range(255)), 1'b1, 1'b0, 8'h00);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (exp_q.size() != 0) begin
      $display("%0d expected items never arrived", exp_q.size());
      n_err++;
    end

    $display("decoded %0d input items over %0d strings into %0d output items",
             n_items, n_strings, n_results);
    $display("entities whole, cut short and restarted, with random stalls on both sides");
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/xeu_pkg.sv
rtl/core/xeu_front.sv
rtl/core/xeu_fifo.sv
rtl/core/xeu_back.sv
rtl/core/xml_entity_unescape_unit.sv
rtl/core/xeu_checker.sv
tb/sv/tb_xml_entity_unescape_unit.sv
